// ===== hw/rtl/sbc_pkg.sv =====
`default_nettype none
package sbc_pkg;

   localparam int NUM_AXES = 3;
   // divider depth in registers, input to quotient
   localparam int DIV_LAT  = 21;
   localparam int QBITS    = 18;
   localparam logic [16:0] ONE_Q16 = 17'd65536;

   localparam logic [2:0] REG_MIN_X = 3'd0;
   localparam logic [2:0] REG_MAX_X = 3'd1;
   localparam logic [2:0] REG_MIN_Y = 3'd2;
   localparam logic [2:0] REG_MAX_Y = 3'd3;
   localparam logic [2:0] REG_MIN_Z = 3'd4;
   localparam logic [2:0] REG_MAX_Z = 3'd5;

   typedef struct packed {
      logic        ok;
      logic [16:0] lo;
      logic [16:0] hi;
   } slab_type;

   // one axis of the interval narrowing: min plane, then max plane
   function automatic slab_type slab_step(input slab_type cur, input logic dpos,
                                          input logic dneg, input logic zrej,
                                          input logic signed [18:0] tl,
                                          input logic signed [18:0] th);
      slab_type nxt;
      logic signed [18:0] lo_s;
      logic signed [18:0] hi_s;
      logic ok;
      ok   = cur.ok;
      lo_s = signed'({2'b00, cur.lo});
      hi_s = signed'({2'b00, cur.hi});
      if (ok) begin
         if (dpos) begin
            if (tl > hi_s) ok = 1'b0;
            else if (tl > lo_s) lo_s = tl;
         end else if (dneg) begin
            if (tl < lo_s) ok = 1'b0;
            else if (tl < hi_s) hi_s = tl;
         end else if (zrej) begin
            ok = 1'b0;
         end
      end
      if (ok) begin
         if (dpos) begin
            if (th < lo_s) ok = 1'b0;
            else if (th < hi_s) hi_s = th;
         end else if (dneg) begin
            if (th > hi_s) ok = 1'b0;
            else if (th > lo_s) lo_s = th;
         end
      end
      nxt.ok = ok;
      nxt.lo = lo_s[16:0];
      nxt.hi = hi_s[16:0];
      return nxt;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/sbc_div.sv =====
`default_nettype none
// Pipelined restoring divider: (num * 65536) / den, truncated toward zero,
// magnitude saturated to 2^18-1. One quotient bit per stage.
module sbc_div (
   input  wire logic               clock,
   input  wire logic               en,
   input  wire logic signed [32:0] num,
   input  wire logic signed [32:0] den,
   output logic signed [18:0]      quo
);
   localparam int NSTG = sbc_pkg::QBITS;

   logic [48:0] mag_ff;
   logic [32:0] dmag_ff;
   logic        neg_ff;

   logic [48:0]           rem_ff  [0:NSTG];
   logic [32:0]           d_ff    [0:NSTG];
   logic [NSTG-1:0]       q_ff    [0:NSTG];
   logic                  sat_ff  [0:NSTG];
   logic                  sgn_ff  [0:NSTG];
   logic signed [18:0]    quo_ff;

   logic [32:0] num_abs;
   logic [32:0] den_abs;
   assign num_abs = num[32] ? 33'(-num) : 33'(num);
   assign den_abs = den[32] ? 33'(-den) : 33'(den);

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff  <= {num_abs[32:0], 16'd0};
         dmag_ff <= den_abs;
         neg_ff  <= num[32] ^ den[32];
         // overflow check against den << 18
         rem_ff[0] <= mag_ff;
         d_ff[0]   <= dmag_ff;
         q_ff[0]   <= '0;
         sat_ff[0] <= ({2'b00, mag_ff} >= {dmag_ff, 18'd0});
         sgn_ff[0] <= neg_ff;
      end
   end

   for (genvar j = 0; j < NSTG; j++) begin : g_stg
      logic [50:0] shd;
      logic        take;
      assign shd  = {18'd0, d_ff[j]} << (NSTG - 1 - j);
      assign take = ({2'b00, rem_ff[j]} >= shd);
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j+1] <= take ? 49'({2'b00, rem_ff[j]} - shd) : rem_ff[j];
            d_ff[j+1]   <= d_ff[j];
            q_ff[j+1]   <= q_ff[j] | (take ? (NSTG'(1) << (NSTG - 1 - j)) : '0);
            sat_ff[j+1] <= sat_ff[j];
            sgn_ff[j+1] <= sgn_ff[j];
         end
      end
   end

   logic [NSTG-1:0] qmag;
   assign qmag = sat_ff[NSTG] ? {NSTG{1'b1}} : q_ff[NSTG];

   always_ff @(posedge clock) begin
      if (en) begin
         quo_ff <= sgn_ff[NSTG] ? 19'(-signed'({1'b0, qmag})) : signed'({1'b0, qmag});
      end
   end

   assign quo = quo_ff;
endmodule
`default_nettype wire

// ===== hw/rtl/segment_box_clipper_3d.sv =====
// Throughput: one item per cycle while the skid register is empty; the 21-stage
// pipelined divider (one quotient bit per quotient stage) plus the input stage,
// three slab stages, a multiply and a round stage set the depth.
// A skid register holds one result while rsp_ready is low; the pipeline then stalls.
// Reset (synchronous, active high) clears all valid bits and the box registers to 0.
`default_nettype none
module segment_box_clipper_3d (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [2:0]         csr_index,
   input  wire logic [31:0]        csr_data,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic signed [31:0] req_start_x,
   input  wire logic signed [31:0] req_start_y,
   input  wire logic signed [31:0] req_start_z,
   input  wire logic signed [31:0] req_end_x,
   input  wire logic signed [31:0] req_end_y,
   input  wire logic signed [31:0] req_end_z,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic                    rsp_hit,
   output logic [16:0]             rsp_t_enter,
   output logic [16:0]             rsp_t_exit,
   output logic signed [31:0]      rsp_clip_start_x,
   output logic signed [31:0]      rsp_clip_start_y,
   output logic signed [31:0]      rsp_clip_start_z,
   output logic signed [31:0]      rsp_clip_end_x,
   output logic signed [31:0]      rsp_clip_end_y,
   output logic signed [31:0]      rsp_clip_end_z
);
   localparam int NA = sbc_pkg::NUM_AXES;
   localparam int DL = sbc_pkg::DIV_LAT;

   // ---- box registers ----
   logic signed [31:0] bmin_ff [NA];
   logic signed [31:0] bmax_ff [NA];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < NA; a++) begin
            bmin_ff[a] <= '0;
            bmax_ff[a] <= '0;
         end
      end else if (csr_valid) begin
         case (csr_index)
            sbc_pkg::REG_MIN_X: bmin_ff[0] <= csr_data;
            sbc_pkg::REG_MAX_X: bmax_ff[0] <= csr_data;
            sbc_pkg::REG_MIN_Y: bmin_ff[1] <= csr_data;
            sbc_pkg::REG_MAX_Y: bmax_ff[1] <= csr_data;
            sbc_pkg::REG_MIN_Z: bmin_ff[2] <= csr_data;
            sbc_pkg::REG_MAX_Z: bmax_ff[2] <= csr_data;
            default: ;
         endcase
      end
   end

   // ---- global advance: the whole pipe moves unless the skid slot is full ----
   logic skid_full_ff;
   logic en;
   assign en        = !skid_full_ff;
   assign req_ready = en;

   logic signed [31:0] org_in [NA];
   logic signed [31:0] end_in [NA];
   assign org_in[0] = req_start_x;
   assign org_in[1] = req_start_y;
   assign org_in[2] = req_start_z;
   assign end_in[0] = req_end_x;
   assign end_in[1] = req_end_y;
   assign end_in[2] = req_end_z;

   // ---- stage 0: direction, plane numerators, zero-direction reject ----
   logic               v0_ff;
   logic signed [31:0] org0_ff  [NA];
   logic signed [32:0] dir0_ff  [NA];
   logic signed [32:0] nlo0_ff  [NA];
   logic signed [32:0] nhi0_ff  [NA];
   logic               zrej0_ff [NA];

   always_ff @(posedge clock) begin
      if (reset) v0_ff <= 1'b0;
      else if (en) v0_ff <= req_valid;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int a = 0; a < NA; a++) begin
            org0_ff[a]  <= org_in[a];
            dir0_ff[a]  <= 33'(end_in[a]) - 33'(org_in[a]);
            nlo0_ff[a]  <= 33'(bmin_ff[a]) - 33'(org_in[a]);
            nhi0_ff[a]  <= 33'(bmax_ff[a]) - 33'(org_in[a]);
            zrej0_ff[a] <= (end_in[a] == org_in[a]) &&
                           ((org_in[a] < bmin_ff[a]) || (org_in[a] > bmax_ff[a]));
         end
      end
   end

   // ---- plane parameters: six dividers in parallel ----
   logic signed [18:0] tlo [NA];
   logic signed [18:0] thi [NA];

   for (genvar a = 0; a < NA; a++) begin : g_div
      sbc_div u_lo (.clock(clock), .en(en), .num(nlo0_ff[a]), .den(dir0_ff[a]),
                    .quo(tlo[a]));
      sbc_div u_hi (.clock(clock), .en(en), .num(nhi0_ff[a]), .den(dir0_ff[a]),
                    .quo(thi[a]));
   end

   // delay line beside the dividers
   logic               vd_ff    [DL];
   logic signed [31:0] orgd_ff  [DL][NA];
   logic signed [32:0] dird_ff  [DL][NA];
   logic               zrejd_ff [DL][NA];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DL; k++) vd_ff[k] <= 1'b0;
      end else if (en) begin
         vd_ff[0] <= v0_ff;
         for (int k = 1; k < DL; k++) vd_ff[k] <= vd_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         orgd_ff[0]  <= org0_ff;
         dird_ff[0]  <= dir0_ff;
         zrejd_ff[0] <= zrej0_ff;
         for (int k = 1; k < DL; k++) begin
            orgd_ff[k]  <= orgd_ff[k-1];
            dird_ff[k]  <= dird_ff[k-1];
            zrejd_ff[k] <= zrejd_ff[k-1];
         end
      end
   end

   // ---- slab stages: one axis per stage, x then y then z ----
   logic               vs_ff   [NA];
   sbc_pkg::slab_type  sl_ff   [NA];
   logic signed [31:0] orgs_ff [NA][NA];
   logic signed [32:0] dirs_ff [NA][NA];
   logic               zrjs_ff [NA][NA];
   logic signed [18:0] tls_ff  [NA][NA];
   logic signed [18:0] ths_ff  [NA][NA];

   sbc_pkg::slab_type sl_init;
   assign sl_init = '{ok: 1'b1, lo: 17'd0, hi: sbc_pkg::ONE_Q16};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NA; s++) vs_ff[s] <= 1'b0;
      end else if (en) begin
         vs_ff[0] <= vd_ff[DL-1];
         for (int s = 1; s < NA; s++) vs_ff[s] <= vs_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sl_ff[0]   <= sbc_pkg::slab_step(sl_init, !dird_ff[DL-1][0][32] &&
                          (dird_ff[DL-1][0] != '0), dird_ff[DL-1][0][32],
                          zrejd_ff[DL-1][0], tlo[0], thi[0]);
         orgs_ff[0] <= orgd_ff[DL-1];
         dirs_ff[0] <= dird_ff[DL-1];
         zrjs_ff[0] <= zrejd_ff[DL-1];
         tls_ff[0]  <= tlo;
         ths_ff[0]  <= thi;
         for (int s = 1; s < NA; s++) begin
            sl_ff[s]   <= sbc_pkg::slab_step(sl_ff[s-1], !dirs_ff[s-1][s][32] &&
                             (dirs_ff[s-1][s] != '0), dirs_ff[s-1][s][32],
                             zrjs_ff[s-1][s], tls_ff[s-1][s], ths_ff[s-1][s]);
            orgs_ff[s] <= orgs_ff[s-1];
            dirs_ff[s] <= dirs_ff[s-1];
            zrjs_ff[s] <= zrjs_ff[s-1];
            tls_ff[s]  <= tls_ff[s-1];
            ths_ff[s]  <= ths_ff[s-1];
         end
      end
   end

   // ---- multiply stage: dir * t for both parameters ----
   logic               vm_ff;
   sbc_pkg::slab_type  slm_ff;
   logic signed [31:0] orgm_ff [NA];
   logic signed [50:0] plo_ff  [NA];
   logic signed [50:0] phi_ff  [NA];

   always_ff @(posedge clock) begin
      if (reset) vm_ff <= 1'b0;
      else if (en) vm_ff <= vs_ff[NA-1];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         slm_ff <= sl_ff[NA-1];
         for (int a = 0; a < NA; a++) begin
            orgm_ff[a] <= orgs_ff[NA-1][a];
            plo_ff[a]  <= 51'(dirs_ff[NA-1][a]) * 51'(signed'({1'b0, sl_ff[NA-1].lo}));
            phi_ff[a]  <= 51'(dirs_ff[NA-1][a]) * 51'(signed'({1'b0, sl_ff[NA-1].hi}));
         end
      end
   end

   // ---- round stage: org + round-half-up(p / 65536); miss gives zeros ----
   logic signed [50:0] rlo [NA];
   logic signed [50:0] rhi [NA];
   always_comb begin
      for (int a = 0; a < NA; a++) begin
         rlo[a] = plo_ff[a] + 51'sd32768;
         rhi[a] = phi_ff[a] + 51'sd32768;
      end
   end

   logic               vf_ff;
   logic               hitf_ff;
   logic [16:0]        tef_ff;
   logic [16:0]        txf_ff;
   logic signed [31:0] csf_ff [NA];
   logic signed [31:0] cef_ff [NA];

   always_ff @(posedge clock) begin
      if (reset) vf_ff <= 1'b0;
      else if (en) vf_ff <= vm_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hitf_ff <= slm_ff.ok;
         tef_ff  <= slm_ff.ok ? slm_ff.lo : '0;
         txf_ff  <= slm_ff.ok ? slm_ff.hi : '0;
         for (int a = 0; a < NA; a++) begin
            csf_ff[a] <= slm_ff.ok ? orgm_ff[a] + rlo[a][47:16] : '0;
            cef_ff[a] <= slm_ff.ok ? orgm_ff[a] + rhi[a][47:16] : '0;
         end
      end
   end

   // ---- skid slot: catches the last stage when the consumer stalls ----
   logic               hitk_ff;
   logic [16:0]        tek_ff;
   logic [16:0]        txk_ff;
   logic signed [31:0] csk_ff [NA];
   logic signed [31:0] cek_ff [NA];

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_full_ff <= 1'b0;
      end else if (skid_full_ff) begin
         if (rsp_ready) skid_full_ff <= 1'b0;
      end else if (vf_ff && !rsp_ready) begin
         skid_full_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hitk_ff <= hitf_ff;
         tek_ff  <= tef_ff;
         txk_ff  <= txf_ff;
         csk_ff  <= csf_ff;
         cek_ff  <= cef_ff;
      end
   end

   assign rsp_valid        = skid_full_ff | vf_ff;
   assign rsp_hit          = skid_full_ff ? hitk_ff   : hitf_ff;
   assign rsp_t_enter      = skid_full_ff ? tek_ff    : tef_ff;
   assign rsp_t_exit       = skid_full_ff ? txk_ff    : txf_ff;
   assign rsp_clip_start_x = skid_full_ff ? csk_ff[0] : csf_ff[0];
   assign rsp_clip_start_y = skid_full_ff ? csk_ff[1] : csf_ff[1];
   assign rsp_clip_start_z = skid_full_ff ? csk_ff[2] : csf_ff[2];
   assign rsp_clip_end_x   = skid_full_ff ? cek_ff[0] : cef_ff[0];
   assign rsp_clip_end_y   = skid_full_ff ? cek_ff[1] : cef_ff[1];
   assign rsp_clip_end_z   = skid_full_ff ? cek_ff[2] : cef_ff[2];
endmodule
`default_nettype wire

// ===== hw/rtl/sbc_checker.sv =====
`default_nettype none
module sbc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        rsp_hit,
   input wire logic [16:0] rsp_t_enter,
   input wire logic [16:0] rsp_t_exit
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_t_enter) &&
      $stable(rsp_t_exit) && $stable(rsp_hit))
      else $error("result dropped or changed under stall");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_t_enter == 17'd0 && rsp_t_exit == 17'd0)
      else $error("miss with nonzero parameters");

   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> rsp_t_enter <= rsp_t_exit &&
      rsp_t_exit <= sbc_pkg::ONE_Q16)
      else $error("interval out of order or above one");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");
endmodule

bind segment_box_clipper_3d sbc_checker u_sbc_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_hit(rsp_hit), .rsp_t_enter(rsp_t_enter), .rsp_t_exit(rsp_t_exit)
);
`default_nettype wire
